/* hdl/mfa_pkg.sv */
package mfa_pkg;

   // item kinds
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   localparam int BLOB_COUNT_DEF   = 7;
   localparam int GRID_COLUMNS_DEF = 512;
   localparam int GRID_ROWS_DEF    = 384;

   localparam int KERNEL_CAP = 4095;
   localparam int MIN_DIST2  = 16;
   localparam int FIELD_MAX  = 32767;

   // restoring divide of the 29 bit scaled radius, one quotient bit a cycle
   localparam int DIV_STEPS  = 29;
   // colour mean quotient is 8 bits
   localparam int MEAN_STEPS = 8;

   localparam int COORD_W = 19;
   localparam int POS8_W  = 17;
   localparam int ABS_W   = 19;
   localparam int SQ_W    = 38;
   localparam int D2_W    = 31;
   localparam int R2_W    = 21;
   localparam int V_W     = 12;
   localparam int WSUM_W  = 20;

   // per cycle commands from the sequencer to the cells
   typedef struct packed {
      logic square;
      logic div_init;
      logic div_step;
      logic weigh;
   } mfa_ctrl_type;

   typedef struct packed {
      logic init;
      logic step;
   } mfa_mean_ctrl_type;

endpackage

/* hdl/mfa_cell.sv */
module mfa_cell
   import mfa_pkg::*;
#(
   parameter int FIELD_W = 15,
   parameter int SUM_W   = 23
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [COORD_W-1:0]  load_cx,
   input  logic [COORD_W-1:0]  load_cy,
   input  logic [R2_W-1:0]     load_r2,
   input  logic [7:0]          load_edge,
   input  logic [7:0]          load_rgb [3],
   input  logic [POS8_W-1:0]   x8,
   input  logic [POS8_W-1:0]   y8,
   input  mfa_ctrl_type        ctrl,
   input  logic [FIELD_W-1:0]  prev_field,
   input  logic [SUM_W-1:0]    prev_sum [3],
   output logic [FIELD_W-1:0]  acc_field,
   output logic [SUM_W-1:0]    acc_sum [3]
);

   logic                active_ff;
   logic [COORD_W-1:0]  cx_ff, cy_ff;
   logic [R2_W-1:0]     r2_ff;
   logic [7:0]          edge_ff;
   logic [7:0]          rgb_ff [3];
   logic [SQ_W-1:0]     sqx_ff, sqy_ff;
   logic [D2_W-1:0]     div_ff;
   logic [D2_W:0]       rem_ff;
   logic [DIV_STEPS-1:0] dq_ff;
   logic [V_W-1:0]      v_ff;
   logic [WSUM_W-1:0]   wsum_ff [3];
   logic [FIELD_W-1:0]  acc_field_ff;
   logic [SUM_W-1:0]    acc_sum_ff [3];

   logic [COORD_W:0]    dx, dy;
   logic [ABS_W-1:0]    adx, ady;
   logic [D2_W-1:0]     d2_raw, d2_in;
   logic [D2_W:0]       rem_sh;
   logic [DIV_STEPS-1:0] diff;
   logic [V_W-1:0]      v_in;

   // offsets from the blob centre, then magnitudes
   assign dx  = {3'b000, x8} - {cx_ff[COORD_W-1], cx_ff};
   assign dy  = {3'b000, y8} - {cy_ff[COORD_W-1], cy_ff};
   assign adx = dx[COORD_W] ? ABS_W'(-dx) : dx[ABS_W-1:0];
   assign ady = dy[COORD_W] ? ABS_W'(-dy) : dy[ABS_W-1:0];

   assign d2_raw = D2_W'(sqx_ff[SQ_W-1:8]) + D2_W'(sqy_ff[SQ_W-1:8]);
   assign d2_in  = (d2_raw < D2_W'(MIN_DIST2)) ? D2_W'(MIN_DIST2) : d2_raw;

   assign rem_sh = {rem_ff[D2_W-1:0], dq_ff[DIV_STEPS-1]};

   always_comb begin
      diff = dq_ff - DIV_STEPS'(edge_ff);
      v_in = '0;
      if (active_ff && (dq_ff > DIV_STEPS'(edge_ff))) begin
         v_in = (diff > DIV_STEPS'(KERNEL_CAP)) ? V_W'(KERNEL_CAP) : diff[V_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (load) begin
         active_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cx_ff   <= load_cx;
         cy_ff   <= load_cy;
         r2_ff   <= load_r2;
         edge_ff <= load_edge;
         rgb_ff  <= load_rgb;
      end
      if (ctrl.square) begin
         sqx_ff <= adx * adx;
         sqy_ff <= ady * ady;
      end
      if (ctrl.div_init) begin
         div_ff <= d2_in;
         rem_ff <= '0;
         dq_ff  <= {r2_ff, 8'h00};
      end else if (ctrl.div_step) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_ff <= rem_sh - {1'b0, div_ff};
            dq_ff  <= {dq_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            dq_ff  <= {dq_ff[DIV_STEPS-2:0], 1'b0};
         end
      end
      if (ctrl.weigh) begin
         v_ff <= v_in;
         // an empty slot has no colour yet, so it adds nothing
         for (int c = 0; c < 3; c++) begin
            wsum_ff[c] <= active_ff ? v_in * rgb_ff[c] : '0;
         end
      end
      // running sums move one cell down the chain every cycle
      acc_field_ff <= prev_field + FIELD_W'(v_ff);
      for (int c = 0; c < 3; c++) begin
         acc_sum_ff[c] <= prev_sum[c] + SUM_W'(wsum_ff[c]);
      end
   end

   assign acc_field = acc_field_ff;
   assign acc_sum   = acc_sum_ff;

endmodule

/* hdl/mfa_mean.sv */
module mfa_mean
   import mfa_pkg::*;
#(
   parameter int FIELD_W = 15,
   parameter int SUM_W   = 23
) (
   input  logic                clock,
   input  mfa_mean_ctrl_type   ctrl,
   input  logic [FIELD_W-1:0]  field,
   input  logic [SUM_W-1:0]    sums [3],
   output logic [FIELD_W-1:0]  field_out,
   output logic [7:0]          mean [3]
);

   localparam int W = FIELD_W + MEAN_STEPS;

   logic [FIELD_W-1:0] field_ff;
   logic [W-1:0]       rem_ff [3];
   logic [7:0]         q_ff [3];
   logic [2:0]         shift_ff;
   logic [W-1:0]       trial;

   // quotient is known to be below 256, so only eight trial subtracts
   assign trial = W'(field_ff) << shift_ff;

   always_ff @(posedge clock) begin
      if (ctrl.init) begin
         field_ff <= field;
         shift_ff <= 3'(MEAN_STEPS - 1);
         for (int c = 0; c < 3; c++) begin
            rem_ff[c] <= W'(sums[c]);
            q_ff[c]   <= '0;
         end
      end else if (ctrl.step) begin
         shift_ff <= shift_ff - 3'd1;
         for (int c = 0; c < 3; c++) begin
            if (rem_ff[c] >= trial) begin
               rem_ff[c] <= rem_ff[c] - trial;
               q_ff[c]   <= {q_ff[c][6:0], 1'b1};
            end else begin
               q_ff[c]   <= {q_ff[c][6:0], 1'b0};
            end
         end
      end
   end

   assign field_out = field_ff;
   assign mean      = q_ff;

endmodule

/* hdl/metaball_field_accumulate.sv */
// Metaball field engine. A load word (req_action = 0) writes one blob slot and does not
// raise busy; a slot number at or above BLOB_COUNT is dropped. An evaluate word
// (req_action = 1) returns exactly one result word, and busy stays high until the cycle
// that shows rsp_strobe, so a new word may be started on that cycle. The time is set
// by the per-blob restoring divider (one quotient bit per step), the ripple of partial
// sums down the chain of blob cells (one cell per cycle) and the 8 step colour mean
// divider. rsp_strobe is high for one cycle only and the result cannot be held off,
// so the receiver must take it then. Cells outside the grid give an all zero result.
module metaball_field_accumulate
   import mfa_pkg::*;
#(
   parameter int BLOB_COUNT   = BLOB_COUNT_DEF,
   parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
   parameter int GRID_ROWS    = GRID_ROWS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [2:0]          req_blob_slot,
   input  logic signed [18:0]  req_center_x,
   input  logic signed [18:0]  req_center_y,
   input  logic [20:0]         req_radius_sq,
   input  logic [7:0]          req_edge_level,
   input  logic [7:0]          req_blob_red,
   input  logic [7:0]          req_blob_green,
   input  logic [7:0]          req_blob_blue,
   input  logic [8:0]          req_cell_x,
   input  logic [8:0]          req_cell_y,
   output logic                rsp_strobe,
   output logic [14:0]         rsp_field_sum,
   output logic [7:0]          rsp_mean_red,
   output logic [7:0]          rsp_mean_green,
   output logic [7:0]          rsp_mean_blue
);

   // accumulator widths follow from the blob count
   localparam int FIELD_W = $clog2(BLOB_COUNT * KERNEL_CAP + 1);
   localparam int SUM_W   = $clog2(BLOB_COUNT * KERNEL_CAP * 255 + 1);
   localparam int CNT_MAX = (DIV_STEPS > BLOB_COUNT) ? DIV_STEPS : BLOB_COUNT;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SQ    = 4'd1;
   localparam logic [3:0] ST_DINIT = 4'd2;
   localparam logic [3:0] ST_DIV   = 4'd3;
   localparam logic [3:0] ST_WT    = 4'd4;
   localparam logic [3:0] ST_CHAIN = 4'd5;
   localparam logic [3:0] ST_MINIT = 4'd6;
   localparam logic [3:0] ST_MEAN  = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [POS8_W-1:0]   x8_ff, y8_ff;
   logic                outside_ff;
   logic                strobe_ff;
   logic [14:0]         field_sum_ff;
   logic [7:0]          mean_ff [3];

   logic                take;
   logic                take_load;
   mfa_ctrl_type        ctrl;
   mfa_mean_ctrl_type   mctrl;
   logic [7:0]          load_rgb [3];

   // chain links: link 0 feeds zeros into the first cell
   logic [FIELD_W-1:0]  link_field [BLOB_COUNT+1];
   logic [SUM_W-1:0]    link_sum   [BLOB_COUNT+1][3];

   logic [FIELD_W-1:0]  mean_field;
   logic [7:0]          mean_q [3];
   logic [31:0]         field_wide;

   assign busy      = (state_ff != ST_IDLE);
   assign take      = start && !busy;
   assign take_load = take && (req_action == ACT_LOAD);
   assign load_rgb  = '{req_blob_red, req_blob_green, req_blob_blue};

   assign link_field[0] = '0;
   assign link_sum[0]   = '{default: '0};

   // one cell per blob slot
   for (genvar i = 0; i < BLOB_COUNT; i++) begin : g_cell
      mfa_cell #(
         .FIELD_W (FIELD_W),
         .SUM_W   (SUM_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (take_load && (int'(req_blob_slot) == i)),
         .load_cx    (req_center_x),
         .load_cy    (req_center_y),
         .load_r2    (req_radius_sq),
         .load_edge  (req_edge_level),
         .load_rgb   (load_rgb),
         .x8         (x8_ff),
         .y8         (y8_ff),
         .ctrl       (ctrl),
         .prev_field (link_field[i]),
         .prev_sum   (link_sum[i]),
         .acc_field  (link_field[i+1]),
         .acc_sum    (link_sum[i+1])
      );
   end

   mfa_mean #(
      .FIELD_W (FIELD_W),
      .SUM_W   (SUM_W)
   ) u_mean (
      .clock     (clock),
      .ctrl      (mctrl),
      .field     (link_field[BLOB_COUNT]),
      .sums      (link_sum[BLOB_COUNT]),
      .field_out (mean_field),
      .mean      (mean_q)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ctrl     = '0;
      mctrl    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take && (req_action == ACT_EVAL)) begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            ctrl.square = 1'b1;
            state_in    = ST_DINIT;
         end
         ST_DINIT: begin
            ctrl.div_init = 1'b1;
            count_in      = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
            count_in      = count_ff + 1'b1;
            if (count_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_WT;
            end
         end
         ST_WT: begin
            ctrl.weigh = 1'b1;
            count_in   = '0;
            state_in   = ST_CHAIN;
         end
         ST_CHAIN: begin
            // wait while the partial sums ripple down the chain of cells
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(BLOB_COUNT - 1)) begin
               state_in = ST_MINIT;
            end
         end
         ST_MINIT: begin
            mctrl.init = 1'b1;
            count_in   = '0;
            state_in   = ST_MEAN;
         end
         ST_MEAN: begin
            mctrl.step = 1'b1;
            count_in   = count_ff + 1'b1;
            if (count_ff == CNT_W'(MEAN_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= (state_ff == ST_DONE);
      end
   end

   // field sum saturates at the port width, means use the full sum
   assign field_wide = 32'(mean_field);

   always_ff @(posedge clock) begin
      if (take && (req_action == ACT_EVAL)) begin
         x8_ff      <= {req_cell_x, 8'h00};
         y8_ff      <= {req_cell_y, 8'h00};
         outside_ff <= (32'(req_cell_x) >= GRID_COLUMNS) || (32'(req_cell_y) >= GRID_ROWS);
      end
      if (state_ff == ST_DONE) begin
         if (outside_ff || (field_wide == 32'd0)) begin
            field_sum_ff <= '0;
            mean_ff      <= '{default: '0};
         end else begin
            field_sum_ff <= (field_wide > 32'(FIELD_MAX)) ? 15'(FIELD_MAX) : field_wide[14:0];
            mean_ff      <= mean_q;
         end
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_field_sum  = field_sum_ff;
   assign rsp_mean_red   = mean_ff[0];
   assign rsp_mean_green = mean_ff[1];
   assign rsp_mean_blue  = mean_ff[2];

endmodule

/* hdl/mfa_checker.sv */
module mfa_checker
   import mfa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_action,
   input  logic                rsp_strobe,
   input  logic [14:0]         rsp_field_sum,
   input  logic [7:0]          rsp_mean_red,
   input  logic [7:0]          rsp_mean_green,
   input  logic [7:0]          rsp_mean_blue
);

   // an evaluate word holds the block busy
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_EVAL)) |=> busy)
      else $error("evaluate word did not raise busy");

   // a load word raises neither busy nor a result
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_LOAD)) |=> (!busy && !rsp_strobe))
      else $error("load word raised busy or a result");

   // a result ends the busy period
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result outside an evaluate");

   // empty field gives zero means
   a_zero_mean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_field_sum == 15'd0)) |->
         ((rsp_mean_red == 8'd0) && (rsp_mean_green == 8'd0) && (rsp_mean_blue == 8'd0)))
      else $error("nonzero mean with empty field");

endmodule

bind metaball_field_accumulate mfa_checker u_mfa_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_action     (req_action),
   .rsp_strobe     (rsp_strobe),
   .rsp_field_sum  (rsp_field_sum),
   .rsp_mean_red   (rsp_mean_red),
   .rsp_mean_green (rsp_mean_green),
   .rsp_mean_blue  (rsp_mean_blue)
);

/* bench/tb_metaball_field_accumulate.sv */
module tb_metaball_field_accumulate;
   import mfa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BLOBS = BLOB_COUNT_DEF;
   localparam int NUM_COLS  = GRID_COLUMNS_DEF;
   localparam int NUM_ROWS  = GRID_ROWS_DEF;
   localparam int RANDOM_WORDS = 1350;
   // evaluate latency in cycles, which follows from the blob count
   localparam int EVAL_CYCLES = NUM_BLOBS + 43;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = ACT_LOAD;
   logic [2:0] req_blob_slot = '0;
   logic signed [18:0] req_center_x = '0;
   logic signed [18:0] req_center_y = '0;
   logic [20:0] req_radius_sq = '0;
   logic [7:0] req_edge_level = '0;
   logic [7:0] req_blob_red = '0;
   logic [7:0] req_blob_green = '0;
   logic [7:0] req_blob_blue = '0;
   logic [8:0] req_cell_x = '0;
   logic [8:0] req_cell_y = '0;
   logic rsp_strobe;
   logic [14:0] rsp_field_sum;
   logic [7:0] rsp_mean_red, rsp_mean_green, rsp_mean_blue;

   metaball_field_accumulate u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct {
      logic act;
      logic [2:0] slot;
      logic signed [18:0] cx, cy;
      logic [20:0] r2;
      logic [7:0] edge_lvl, red, green, blue;
      logic [8:0] x, y;
   } word_t;

   typedef struct {
      logic [14:0] field;
      logic [7:0] red, green, blue;
   } pixel_t;

   // mirror of the blob store
   logic [NUM_BLOBS-1:0] slot_live;
   logic signed [18:0] mir_cx [NUM_BLOBS];
   logic signed [18:0] mir_cy [NUM_BLOBS];
   logic [20:0] mir_r2 [NUM_BLOBS];
   logic [7:0] mir_edge [NUM_BLOBS];
   logic [7:0] mir_rgb [NUM_BLOBS][3];

   pixel_t pixel_queue[$];
   int errors = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // applies one word to the mirror; returns 1 with a pixel for an evaluate
   function automatic bit shade_cell(input word_t w, output pixel_t px);
      longint dx, dy, d2, k, v;
      longint field, acc [3];
      px = '{0, 0, 0, 0};
      field = 0;
      acc = '{0, 0, 0};
      if (w.act == ACT_LOAD) begin
         if (w.slot < NUM_BLOBS) begin
            mir_cx[w.slot] = w.cx;
            mir_cy[w.slot] = w.cy;
            mir_r2[w.slot] = w.r2;
            mir_edge[w.slot] = w.edge_lvl;
            mir_rgb[w.slot] = '{w.red, w.green, w.blue};
            slot_live[w.slot] = 1'b1;
         end
         return 0;
      end
      if (w.x >= NUM_COLS || w.y >= NUM_ROWS) return 1;
      for (int b = 0; b < NUM_BLOBS; b++) begin
         if (!slot_live[b]) continue;
         dx = (longint'(w.x) <<< 8) - longint'(mir_cx[b]);
         dy = (longint'(w.y) <<< 8) - longint'(mir_cy[b]);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         d2 = ((dx * dx) >> 8) + ((dy * dy) >> 8);
         if (d2 < MIN_DIST2) d2 = MIN_DIST2;
         k = (longint'(mir_r2[b]) <<< 8) / d2;
         if (k <= mir_edge[b]) continue;
         v = k - mir_edge[b];
         if (v > KERNEL_CAP) v = KERNEL_CAP;
         field += v;
         for (int c = 0; c < 3; c++) acc[c] += v * mir_rgb[b][c];
      end
      if (field != 0) begin
         px.field = (field > FIELD_MAX) ? FIELD_MAX : field;
         px.red = acc[0] / field;
         px.green = acc[1] / field;
         px.blue = acc[2] / field;
      end
      return 1;
   endfunction

   // result check at the rising edge
   always @(posedge clock) begin
      pixel_t want;
      if (!reset && rsp_strobe) begin
         if (pixel_queue.size() == 0) begin
            report("unexpected word", rsp_field_sum, -1);
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_field_sum !== want.field) report("field_sum", rsp_field_sum, want.field);
            if (rsp_mean_red !== want.red) report("mean_red", rsp_mean_red, want.red);
            if (rsp_mean_green !== want.green)
               report("mean_green", rsp_mean_green, want.green);
            if (rsp_mean_blue !== want.blue) report("mean_blue", rsp_mean_blue, want.blue);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 80);
   endfunction

   // drives one word at the falling edge and holds it until taken
   task automatic send_word(input word_t w, input bit check_direct, input pixel_t direct);
      pixel_t px;
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action <= w.act;
      req_blob_slot <= w.slot;
      req_center_x <= w.cx;
      req_center_y <= w.cy;
      req_radius_sq <= w.r2;
      req_edge_level <= w.edge_lvl;
      req_blob_red <= w.red;
      req_blob_green <= w.green;
      req_blob_blue <= w.blue;
      req_cell_x <= w.x;
      req_cell_y <= w.y;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (shade_cell(w, px)) begin
         // typed-in expectations must agree with the mirror too
         if (check_direct && ((px.field != direct.field) || (px.red != direct.red) ||
                              (px.green != direct.green) || (px.blue != direct.blue)))
            report("table row", px.field, direct.field);
         pixel_queue.push_back(px);
      end
   endtask

   function automatic word_t load_word(input int slot, input int cx, input int cy,
                                       input int r2, input int ed, input int r,
                                       input int g, input int b);
      word_t w;
      w = '{ACT_LOAD, slot[2:0], cx[18:0], cy[18:0], r2[20:0], ed[7:0], r[7:0], g[7:0],
            b[7:0], $urandom(), $urandom()};
      return w;
   endfunction

   function automatic word_t eval_word(input int x, input int y);
      word_t w;
      w = '{ACT_EVAL, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), x[8:0], y[8:0]};
      return w;
   endfunction

   // blob placed somewhere around the grid, sometimes far out
   function automatic word_t random_load();
      int cx, cy, r2;
      if ($urandom_range(0, 9) == 0) begin
         cx = $urandom();
         cy = $urandom();
         r2 = $urandom();
      end else begin
         cx = $urandom_range(0, 140000) - 4000;
         cy = $urandom_range(0, 105000) - 4000;
         r2 = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(16, 300000);
      end
      return load_word($urandom_range(0, 7), cx, cy, r2, $urandom(), $urandom(),
                       $urandom(), $urandom());
   endfunction

   typedef struct {
      word_t w;
      bit typed;
      pixel_t want;
   } row_t;

   initial begin
      row_t rows[$];
      pixel_t zero_px, none;
      word_t w;
      zero_px = '{0, 0, 0, 0};
      none = zero_px;
      slot_live = '0;
      for (int b = 0; b < NUM_BLOBS; b++) begin
         mir_cx[b] = 0; mir_cy[b] = 0; mir_r2[b] = 0; mir_edge[b] = 0;
         mir_rgb[b] = '{0, 0, 0};
      end

      // empty field right after reset, corners and off-grid cells
      rows.push_back('{eval_word(0, 0), 1, zero_px});
      rows.push_back('{eval_word(511, 383), 1, zero_px});
      rows.push_back('{eval_word(511, 511), 1, zero_px});
      rows.push_back('{eval_word(0, 384), 1, zero_px});
      // dropped slot leaves the field empty
      rows.push_back('{load_word(7, 0, 0, 2097151, 0, 255, 255, 255), 0, none});
      rows.push_back('{eval_word(0, 0), 1, zero_px});
      // one full-size blob at the origin: capped kernel, pure colour
      rows.push_back('{load_word(0, 0, 0, 2097151, 0, 255, 0, 128), 0, none});
      rows.push_back('{eval_word(0, 0), 1, '{4095, 255, 0, 128}});
      rows.push_back('{eval_word(0, 400), 1, zero_px});
      rows.push_back('{eval_word(300, 200), 0, none});
      rows.push_back('{eval_word(511, 383), 0, none});
      // extreme centres and edge at the top
      rows.push_back('{load_word(1, -262144, -262144, 2097151, 255, 0, 255, 0), 0, none});
      rows.push_back('{load_word(2, 262143, 262143, 0, 255, 1, 2, 3), 0, none});
      rows.push_back('{eval_word(0, 0), 0, none});
      rows.push_back('{eval_word(511, 383), 0, none});
      // fill the rest, reload a slot, then evaluate around
      for (int s = 3; s < NUM_BLOBS; s++)
         rows.push_back('{load_word(s, s * 9000, s * 7000, 50000, 10, 40 * s, 200, 30),
                          0, none});
      rows.push_back('{load_word(0, 100 << 8, 100 << 8, 20000, 255, 9, 99, 199), 0, none});
      rows.push_back('{eval_word(100, 100), 0, none});
      rows.push_back('{eval_word(40, 30), 0, none});
      rows.push_back('{eval_word(256, 192), 0, none});

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);

      // random words: mostly evaluates, steady trickle of blob loads
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 25) w = random_load();
         else if (r < 30) w = eval_word($urandom(), $urandom());
         else w = eval_word($urandom_range(0, NUM_COLS - 1), $urandom_range(0, NUM_ROWS - 1));
         send_word(w, 0, none);
      end
      @(negedge clock);
      start <= 1'b0;

      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (EVAL_CYCLES + 10) @(posedge clock);
      if (errors == 0) begin
         $display("tb_metaball_field_accumulate: PASS");
      end else begin
         $display("tb_metaball_field_accumulate: FAIL");
      end
      $finish;
   end

   // watchdog, far beyond the slowest run
   initial begin
      #(4ns * 1400 * (EVAL_CYCLES + 90) * 3);
      $display("tb_metaball_field_accumulate: FAIL");
      $finish;
   end

endmodule
